// ===== rtl/mbrot_pkg.sv =====
// Shared types and constants for the Mandelbrot escape-time block.
package mbrot_pkg;

  localparam int IN_W    = 32;
  localparam int COUNT_W = 10;

  localparam logic [COUNT_W-1:0] LIMIT_RESET = COUNT_W'(200);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ZERO,
    ST_MUL,
    ST_SUM,
    ST_TEST
  } state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic sum;
    logic update;
  } dp_cmd_t;

  typedef struct packed {
    logic escape;
  } dp_status_t;

endpackage

// ===== rtl/mbrot_mul.sv =====
// Signed multiplier built from four half-width partial products, with registered partial products and a registered sum.
module mbrot_mul #(
  parameter int W = 34
) (
  input  logic                  clk,
  input  logic                  pp_en,
  input  logic                  sum_en,
  input  logic signed [W-1:0]   a,
  input  logic signed [W-1:0]   b,
  output logic signed [2*W-1:0] p
);

  localparam int L  = (W + 1) / 2;
  localparam int H  = W - L;
  localparam int PW = 2 * W;
  localparam int XW = H + L + 1;

  logic signed [2*H-1:0] pp_hh;
  logic signed [XW-1:0]  pp_hl;
  logic signed [XW-1:0]  pp_lh;
  logic        [2*L-1:0] pp_ll;

  logic signed [PW-1:0]  ext_hh;
  logic signed [PW-1:0]  ext_mid;
  logic signed [PW-1:0]  ext_ll;

  // The upper halves carry the sign, the lower halves are plain magnitudes.
  always_ff @(posedge clk) begin
    if (pp_en) begin
      pp_hh <= (2*H)'($signed(a[W-1:L])) * (2*H)'($signed(b[W-1:L]));
      pp_hl <= XW'($signed(a[W-1:L])) * XW'($signed({1'b0, b[L-1:0]}));
      pp_lh <= XW'($signed({1'b0, a[L-1:0]})) * XW'($signed(b[W-1:L]));
      pp_ll <= (2*L)'(a[L-1:0]) * (2*L)'(b[L-1:0]);
    end
  end

  assign ext_hh  = {{(PW-2*H){pp_hh[2*H-1]}}, pp_hh};
  assign ext_mid = {{(PW-XW){pp_hl[XW-1]}}, pp_hl} + {{(PW-XW){pp_lh[XW-1]}}, pp_lh};
  assign ext_ll  = {{(PW-2*L){1'b0}}, pp_ll};

  always_ff @(posedge clk) begin
    if (sum_en) begin
      p <= (ext_hh <<< (2*L)) + (ext_mid <<< L) + ext_ll;
    end
  end

endmodule

// ===== rtl/mbrot_datapath.sv =====
// Datapath: point and iterate registers, three split multipliers, escape test and update.
module mbrot_datapath #(
  parameter int FRAC_BITS = 28
) (
  input  logic                                clk,
  input  logic signed [mbrot_pkg::IN_W-1:0]   c_real,
  input  logic signed [mbrot_pkg::IN_W-1:0]   c_imag,
  input  mbrot_pkg::dp_cmd_t                  cmd,
  output mbrot_pkg::dp_status_t               status
);

  import mbrot_pkg::*;

  localparam int W  = FRAC_BITS + 6;
  localparam int PW = 2 * W;
  localparam int SW = W + 2;
  localparam int XW = (W > IN_W) ? W : IN_W;

  localparam logic signed [W-1:0] Z_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] Z_MIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W:0]   FOUR  = $signed((W+1)'(4) << FRAC_BITS);

  logic signed [W-1:0]  zr, zi, cr, ci;
  logic signed [PW-1:0] p_rr, p_ii, p_ri;
  logic signed [PW-1:0] sh_rr, sh_ii, sh_ri;
  logic signed [W-1:0]  r2, i2, twoxy;
  logic signed [W:0]    mag;
  logic signed [SW-1:0] zr_sum, zi_sum;
  logic signed [XW-1:0] cr_ext, ci_ext;

  function automatic logic signed [W-1:0] sat_prod(input logic signed [PW-1:0] v);
    logic [PW-W:0] top;
    top = v[PW-1:W-1];
    if (&top || ~|top) return v[W-1:0];
    else if (v[PW-1])  return Z_MIN;
    else               return Z_MAX;
  endfunction

  function automatic logic signed [W-1:0] sat_sum(input logic signed [SW-1:0] v);
    logic [SW-W:0] top;
    top = v[SW-1:W-1];
    if (&top || ~|top) return v[W-1:0];
    else if (v[SW-1])  return Z_MIN;
    else               return Z_MAX;
  endfunction

  function automatic logic signed [W-1:0] sat_in(input logic signed [XW-1:0] v);
    logic [XW-W:0] top;
    top = v[XW-1:W-1];
    if (&top || ~|top) return v[W-1:0];
    else if (v[XW-1])  return Z_MIN;
    else               return Z_MAX;
  endfunction

  mbrot_mul #(.W(W)) u_mul_rr (
    .clk(clk), .pp_en(cmd.mul), .sum_en(cmd.sum), .a(zr), .b(zr), .p(p_rr)
  );

  mbrot_mul #(.W(W)) u_mul_ii (
    .clk(clk), .pp_en(cmd.mul), .sum_en(cmd.sum), .a(zi), .b(zi), .p(p_ii)
  );

  mbrot_mul #(.W(W)) u_mul_ri (
    .clk(clk), .pp_en(cmd.mul), .sum_en(cmd.sum), .a(zr), .b(zi), .p(p_ri)
  );

  // Arithmetic shifts round toward minus infinity; the cross term keeps one
  // more bit to fold in the factor of two.
  assign sh_rr = p_rr >>> FRAC_BITS;
  assign sh_ii = p_ii >>> FRAC_BITS;
  assign sh_ri = p_ri >>> (FRAC_BITS - 1);

  assign r2    = sat_prod(sh_rr);
  assign i2    = sat_prod(sh_ii);
  assign twoxy = sat_prod(sh_ri);

  assign mag           = (W+1)'(r2) + (W+1)'(i2);
  assign status.escape = (mag > FOUR);

  assign zr_sum = SW'(r2) - SW'(i2) + SW'(cr);
  assign zi_sum = SW'(twoxy) + SW'(ci);

  assign cr_ext = XW'(c_real);
  assign ci_ext = XW'(c_imag);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cr <= sat_in(cr_ext);
      ci <= sat_in(ci_ext);
      zr <= sat_in(cr_ext);
      zi <= sat_in(ci_ext);
    end else if (cmd.update) begin
      zr <= sat_sum(zr_sum);
      zi <= sat_sum(zi_sum);
    end
  end

endmodule

// ===== rtl/mbrot_ctrl.sv =====
// Controller: sequencing state machine, update counter, limit register and result register.
module mbrot_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            cfg_write,
  input  logic [mbrot_pkg::COUNT_W-1:0]   cfg_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [mbrot_pkg::COUNT_W-1:0]   escape_steps,
  output logic                            in_set,
  output mbrot_pkg::dp_cmd_t              cmd,
  input  mbrot_pkg::dp_status_t           status
);

  import mbrot_pkg::*;

  state_t             state, state_next;
  logic [COUNT_W-1:0] iteration_limit;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_inc;
  logic               out_free;
  logic               last_update;
  logic               count_clr;
  logic               out_load;
  logic [COUNT_W-1:0] steps_val;
  logic               in_set_val;

  assign count_inc   = count + COUNT_W'(1);
  assign last_update = (count_inc == iteration_limit);
  assign out_free    = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (iteration_limit == '0) ? ST_ZERO : ST_MUL;
        end
      end
      ST_ZERO: begin
        if (out_free) state_next = ST_IDLE;
      end
      ST_MUL:  state_next = ST_SUM;
      ST_SUM:  state_next = ST_TEST;
      ST_TEST: begin
        if (status.escape || last_update) begin
          if (out_free) state_next = ST_IDLE;
        end else begin
          state_next = ST_MUL;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    count_clr  = 1'b0;
    out_load   = 1'b0;
    steps_val  = count;
    in_set_val = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.load  = in_valid;
        count_clr = in_valid;
      end
      ST_ZERO: begin
        out_load   = out_free;
        steps_val  = '0;
        in_set_val = 1'b1;
      end
      ST_MUL:  cmd.mul = 1'b1;
      ST_SUM:  cmd.sum = 1'b1;
      ST_TEST: begin
        if (status.escape) begin
          out_load = out_free;
        end else if (last_update) begin
          // The final update cannot change the outcome, so it is skipped.
          out_load   = out_free;
          steps_val  = iteration_limit;
          in_set_val = 1'b1;
        end else begin
          cmd.update = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      iteration_limit <= LIMIT_RESET;
      count           <= '0;
      out_valid       <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) iteration_limit <= cfg_data;
      if (count_clr) begin
        count <= '0;
      end else if (cmd.update) begin
        count <= count_inc;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      escape_steps <= steps_val;
      in_set       <= in_set_val;
    end
  end

endmodule

// ===== rtl/mandelbrot_escape_time.sv =====
// Top level of the Mandelbrot escape-time block.
//
// Each transfer on the input channel delivers one point c in signed fixed
// point with FRAC_BITS fraction bits; the block iterates z = z*z + c from
// z = c with saturating Q6 internal values and returns one result: the
// number of updates before |z|^2 exceeded four, or the limit with in_set
// high. One point is worked on at a time. Every update steps through three
// states that drive the three multipliers (a partial-product step, a summing
// step, then the shift, escape test and update step); the final test waits
// until the output register has room.
// A finished result sits in an output register, so the next point is taken
// as soon as that register has room. iteration_limit is written through
// cfg_write and cfg_data; the user must do so only while the block is idle,
// as the block itself does not enforce it. It resets to 200.
module mandelbrot_escape_time #(
  parameter int FRAC_BITS = 28
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [mbrot_pkg::IN_W-1:0]   c_real,
  input  logic signed [mbrot_pkg::IN_W-1:0]   c_imag,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [mbrot_pkg::COUNT_W-1:0]       escape_steps,
  output logic                                in_set,
  input  logic                                cfg_write,
  input  logic [mbrot_pkg::COUNT_W-1:0]       cfg_data
);

  import mbrot_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  mbrot_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .escape_steps (escape_steps),
    .in_set       (in_set),
    .cmd          (cmd),
    .status       (status)
  );

  mbrot_datapath #(.FRAC_BITS(FRAC_BITS)) u_datapath (
    .clk    (clk),
    .c_real (c_real),
    .c_imag (c_imag),
    .cmd    (cmd),
    .status (status)
  );

endmodule
